@@ hw/rtl/smf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding median filter package
// Shared constants, cell entry types and the key comparison of the sorted
// cell chain.
// ----------------------------------------------------------------------------
package smf_pkg;

  localparam int unsigned WINDOW  = 50;
  localparam int unsigned DataW   = 16;
  localparam int unsigned CntW    = $clog2(WINDOW + 1);
  localparam int unsigned AgeW    = $clog2(WINDOW + 1);
  localparam int unsigned MidCell = WINDOW / 2;

  localparam logic [CntW-1:0] CountFull = CntW'(WINDOW);
  localparam logic [AgeW-1:0] AgeOldest = AgeW'(WINDOW - 1);

  // Padding below every sample, a real sample, padding above every sample.
  typedef enum logic [1:0] {
    KIND_LOW  = 2'd0,
    KIND_REAL = 2'd1,
    KIND_HIGH = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [DataW-1:0]  value;
    logic [AgeW-1:0]   age;
  } entry_t;

  // Passed from a cell to the cell below it.
  typedef struct packed {
    entry_t ent;
    logic   gt;
  } down_t;

  // Passed from a cell to the cell above it.
  typedef struct packed {
    logic   rm;
    entry_t ap;
    logic   ap_le;
    kind_e  kind;
  } up_t;

  // Global update mode shared by all cells.
  typedef struct packed {
    logic full;
    logic drop_low;
  } ctrl_t;

  function automatic logic key_gt(entry_t a, entry_t b);
    return {a.kind, a.value} > {b.kind, b.value};
  endfunction

  function automatic entry_t age_inc(entry_t e);
    entry_t r;
    r = e;
    if (e.kind == KIND_REAL) begin
      r.age = e.age + AgeW'(1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/smf_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding median filter cell
// One position of the sorted chain. On each transfer it drops its part of the
// evicted entry and takes the new sample in order, using its neighbours.
// ----------------------------------------------------------------------------
module smf_cell
  import smf_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  input  kind_e rst_kind_i,
  input  wire   load_i,
  input  ctrl_t ctrl_i,
  input  entry_t new_i,
  input  down_t upper_i,
  input  up_t   lower_i,
  output down_t down_o,
  output up_t   up_o
);

  entry_t ent_q, ent_d;
  logic   gt_own;
  logic   rm_here;
  logic   rm_out;
  entry_t ap;
  logic   ap_le;

  always_comb begin
    gt_own = key_gt(ent_q, new_i);
    if (ctrl_i.full) begin
      rm_here = (ent_q.kind == KIND_REAL) && (ent_q.age == AgeOldest);
    end else if (ctrl_i.drop_low) begin
      rm_here = (ent_q.kind == KIND_LOW) && (upper_i.ent.kind != KIND_LOW);
    end else begin
      rm_here = (ent_q.kind == KIND_HIGH) && (lower_i.kind != KIND_HIGH);
    end
    rm_out = lower_i.rm | rm_here;
    ap     = rm_out ? upper_i.ent : ent_q;
    ap_le  = rm_out ? !upper_i.gt : !gt_own;
    if (ap_le) begin
      ent_d = age_inc(ap);
    end else if (lower_i.ap_le) begin
      ent_d = new_i;
    end else begin
      ent_d = age_inc(lower_i.ap);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '{kind: rst_kind_i, value: '0, age: '0};
    end else if (load_i) begin
      ent_q <= ent_d;
    end
  end

  assign down_o = '{ent: ent_q, gt: gt_own};
  assign up_o   = '{rm: rm_out, ap: ap, ap_le: ap_le, kind: ent_q.kind};

endmodule
`default_nettype wire

@@ hw/rtl/sliding_median_filter_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding median filter
// Upper median of the most recent WINDOW samples, kept in a sorted cell chain.
// ----------------------------------------------------------------------------
// Every accepted sample gives one median, registered and offered in the cycle
// after the transfer. One sample can be taken in every cycle unless the median
// output stalls: the whole chain of cells drops the oldest sample (padding
// while filling) and inserts the new one in the same transfer; the median is
// read from the fixed middle cell. Padding entries below and above the real
// samples centre the chain while filling; medians are valid from the first one.
// ----------------------------------------------------------------------------
module sliding_median_filter_top
  import smf_pkg::*;
(
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              sample_valid_i,
  output logic             sample_stall_o,
  input  wire  [DataW-1:0] sample_i,
  output logic             median_valid_o,
  input  wire              median_stall_i,
  output logic [DataW-1:0] median_o
);

  logic            accept;
  logic            out_valid_q;
  logic [CntW-1:0] count_q;
  ctrl_t           ctrl;
  entry_t          new_ent;
  down_t           dn [WINDOW+1];
  up_t             up [WINDOW+1];

  assign sample_stall_o = out_valid_q && median_stall_i;
  assign accept         = sample_valid_i && !sample_stall_o;

  assign ctrl.full     = (count_q == CountFull);
  assign ctrl.drop_low = count_q[0];
  assign new_ent       = '{kind: KIND_REAL, value: sample_i, age: '0};

  assign dn[WINDOW] = '{ent: '{kind: KIND_HIGH, value: '1, age: '0}, gt: 1'b1};
  assign up[0]      = '{rm: 1'b0, ap: new_ent, ap_le: 1'b1, kind: KIND_REAL};

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    localparam kind_e RstKind = (i < MidCell) ? KIND_LOW : KIND_HIGH;
    smf_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .rst_kind_i(RstKind),
      .load_i    (accept),
      .ctrl_i    (ctrl),
      .new_i     (new_ent),
      .upper_i   (dn[i+1]),
      .lower_i   (up[i]),
      .down_o    (dn[i]),
      .up_o      (up[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept && !ctrl.full) begin
        count_q <= count_q + CntW'(1);
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!median_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign median_valid_o = out_valid_q;
  assign median_o       = dn[MidCell].ent.value;

endmodule
`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding median filter testbench
// Drives samples into the filter with random idle cycles on both sides and a
// long output hold-off, keeps its own window of recent samples to work out
// each upper median, and compares every median transfer with the oldest one
// expected.
// ----------------------------------------------------------------------------
module testbench;
  import smf_pkg::*;

  localparam int ClkHalfNs = 4;
  localparam int IdlePct   = 27;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             sample_valid_i;
  logic             sample_stall_o;
  logic [DataW-1:0] sample_i;
  logic             median_valid_o;
  logic             median_stall_i;
  logic [DataW-1:0] median_o;

  logic             idle_on;
  logic             hold_off;
  int unsigned      mismatch_count;

  logic [DataW-1:0] window_ring [WINDOW];
  int unsigned      ring_pos;
  int unsigned      ring_fill;
  logic [DataW-1:0] expected_medians [$];

  sliding_median_filter_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_valid_i (sample_valid_i),
    .sample_stall_o (sample_stall_o),
    .sample_i       (sample_i),
    .median_valid_o (median_valid_o),
    .median_stall_i (median_stall_i),
    .median_o       (median_o)
  );

  always #(ClkHalfNs) clk_i = ~clk_i;

  function automatic logic [DataW-1:0] upper_median();
    logic [DataW-1:0] sorted [WINDOW];
    logic [DataW-1:0] v;
    int               j;
    for (int i = 0; i < ring_fill; i++) begin
      sorted[i] = window_ring[i];
    end
    for (int i = 1; i < ring_fill; i++) begin
      v = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1] > v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
    end
    return sorted[ring_fill / 2];
  endfunction

  task automatic record_sample(input logic [DataW-1:0] s);
    window_ring[ring_pos] = s;
    ring_pos = (ring_pos + 1 == WINDOW) ? 0 : ring_pos + 1;
    if (ring_fill < WINDOW) begin
      ring_fill++;
    end
    expected_medians.push_back(upper_median());
  endtask

  // Called just after a rising edge; returns just after the edge of the transfer.
  task automatic send_sample(input logic [DataW-1:0] s);
    if (idle_on) begin
      while ($urandom_range(0, 99) < IdlePct) begin
        sample_valid_i <= 1'b0;
        sample_i       <= DataW'($urandom());
        @(posedge clk_i);
      end
    end
    sample_valid_i <= 1'b1;
    sample_i       <= s;
    do @(posedge clk_i); while (sample_stall_o !== 1'b0);
    record_sample(s);
  endtask

  always @(posedge clk_i) begin
    if (hold_off) begin
      median_stall_i <= 1'b1;
    end else if (idle_on) begin
      median_stall_i <= ($urandom_range(0, 99) < IdlePct);
    end else begin
      median_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : check_median
    logic [DataW-1:0] want;
    if (rst_ni && median_valid_o && !median_stall_i) begin
      if (expected_medians.size() == 0) begin
        $display("%0t: unexpected median, expected none, actual %0d", $time, median_o);
        mismatch_count++;
      end else begin
        want = expected_medians.pop_front();
        if (median_o !== want) begin
          $display("%0t: median mismatch, expected %0d, actual %0d", $time, want, median_o);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_first_sample();
    send_sample('1);
  endtask

  task automatic test_edge_values();
    send_sample('0);
    send_sample('0);
    send_sample(16'h8000);
    send_sample(16'h0001);
    send_sample(16'h7FFF);
    send_sample(16'hFFFE);
    send_sample(16'hAAAA);
    send_sample(16'h5555);
    send_sample('1);
  endtask

  task automatic test_repeated_values();
    repeat (6) send_sample(16'h1234);
    send_sample('0);
    send_sample('1);
    repeat (3) send_sample(16'h1234);
  endtask

  task automatic test_uniform_samples();
    repeat (600) send_sample(DataW'($urandom_range(0, 65535)));
  endtask

  task automatic test_clustered_samples();
    int unsigned base;
    base = $urandom_range(0, 65535 - 8);
    for (int n = 0; n < 400; n++) begin
      if ($urandom_range(0, 99) < 3) begin
        base = $urandom_range(0, 65535 - 8);
      end
      if ($urandom_range(0, 99) < 4) begin
        send_sample($urandom_range(0, 1) ? '1 : '0);
      end else begin
        send_sample(DataW'(base + $urandom_range(0, 7)));
      end
    end
  endtask

  task automatic test_trends_and_steps();
    logic [DataW-1:0] level;
    logic [DataW-1:0] step;
    int               len;
    int               n;
    n = 0;
    while (n < 250) begin
      level = DataW'($urandom());
      len   = $urandom_range(5, 70);
      if ($urandom_range(0, 1)) begin
        step = DataW'($urandom_range(0, 600));
        if ($urandom_range(0, 1)) begin
          step = -step;
        end
      end else begin
        step = '0;
      end
      for (int k = 0; k < len && n < 250; k++) begin
        if (step == '0 && $urandom_range(0, 99) < 5) begin
          send_sample($urandom_range(0, 1) ? '1 : '0);
        end else begin
          send_sample(level);
        end
        level = level + step;
        n++;
      end
    end
  endtask

  task automatic test_full_rate();
    idle_on <= 1'b0;
    repeat (200) send_sample(DataW'($urandom()));
    idle_on <= 1'b1;
  endtask

  task automatic test_output_hold_off();
    idle_on <= 1'b0;
    fork
      begin
        hold_off <= 1'b1;
        repeat ($urandom_range(150, 300)) @(posedge clk_i);
        hold_off <= 1'b0;
      end
      begin
        repeat (100) send_sample(DataW'($urandom()));
      end
    join
    idle_on <= 1'b1;
  endtask

  initial begin
    rst_ni         = 1'b0;
    sample_valid_i = 1'b0;
    sample_i       = '0;
    median_stall_i = 1'b0;
    idle_on        = 1'b1;
    hold_off       = 1'b0;
    mismatch_count = 0;
    ring_pos       = 0;
    ring_fill      = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_first_sample();
    test_edge_values();
    test_repeated_values();
    test_uniform_samples();
    test_full_rate();
    test_clustered_samples();
    test_output_hold_off();
    test_trends_and_steps();

    sample_valid_i <= 1'b0;
    while (expected_medians.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("testbench failed");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/smf_pkg.sv
hw/rtl/smf_cell.sv
hw/rtl/sliding_median_filter_top.sv
test/testbench.sv
